// ----- rtl/lcpe_pkg.sv -----
package lcpe_pkg;

    localparam int PKT_LEN = 10;
    localparam int IDX_W   = $clog2(PKT_LEN);

    typedef logic [7:0]                byte_t;
    typedef logic [PKT_LEN-1:0][7:0]   packet_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    localparam logic [2:0] KIND_STATUS = 3'd0;
    localparam logic [2:0] KIND_POWER  = 3'd1;
    localparam logic [2:0] KIND_BRIGHT = 3'd2;
    localparam logic [2:0] KIND_CCT    = 3'd3;
    localparam logic [2:0] KIND_HSI    = 3'd4;

    localparam byte_t OP_STATUS = 8'h0e;
    localparam byte_t OP_POWER  = 8'h8c;
    localparam byte_t OP_BRIGHT = 8'h8f;
    localparam byte_t OP_CCT    = 8'h82;
    localparam byte_t OP_HSI    = 8'h81;

    localparam logic [9:0]  INTENSITY_MAX = 10'd1000;
    localparam logic [8:0]  HUE_MAX       = 9'd360;
    localparam logic [6:0]  SAT_MAX       = 7'd100;
    localparam logic [10:0] TEMP_MIN      = 11'd80;
    localparam logic [10:0] TEMP_MAX      = 11'd2000;
    localparam logic [10:0] TEMP_WRAP     = 11'd1000;
    localparam logic [10:0] TEMP_OFFSET   = 11'd24;
    localparam logic [4:0]  TINT_SPAN     = 5'd10;
    localparam logic [4:0]  TINT_TOP      = 5'd20;

    localparam logic [16:0] KELVIN_ROUND = 17'd5;
    localparam logic [15:0] DIV10_MULT   = 16'd52429;
    localparam int          DIV10_SHIFT  = 19;
    localparam int          TEMP_RAW_W   = 13;

endpackage

// ----- rtl/lcpe_front.sv -----
module lcpe_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [79:0]            s_tdata,
    input  logic [2:0]             s_tuser,
    input  lcpe_pkg::queue_status_t q_status,
    output logic                   push,
    output lcpe_pkg::packet_t      push_data
);

    logic                                  a_valid_reg, a_valid_next;
    logic [2:0]                            a_kind_reg;
    logic                                  a_power_reg;
    logic [9:0]                            a_v_reg;
    logic [8:0]                            a_h_reg;
    logic [6:0]                            a_s_reg;
    logic [4:0]                            a_g_reg;
    logic [lcpe_pkg::TEMP_RAW_W-1:0]       a_t_reg;

    logic [15:0]  in_intensity, in_kelvin, in_hue;
    logic [15:0]  in_tint;
    logic [7:0]   in_sat;
    logic [16:0]  kelvin_rnd;
    logic [32:0]  div_prod;
    logic [9:0]   v_c;
    logic [8:0]   h_c;
    logic [6:0]   s_c;
    logic [4:0]   g_c;
    logic         accept, kind_ok, advance;

    logic [10:0]  t_clamp, t_sum;
    logic [9:0]   t_field;
    logic         wrap;
    lcpe_pkg::packet_t pkt;
    lcpe_pkg::byte_t   csum;

    assign in_intensity = s_tdata[16:1];
    assign in_kelvin    = s_tdata[32:17];
    assign in_tint      = s_tdata[48:33];
    assign in_hue       = s_tdata[64:49];
    assign in_sat       = s_tdata[72:65];

    assign kelvin_rnd = {1'b0, in_kelvin} + lcpe_pkg::KELVIN_ROUND;
    assign div_prod   = 33'(kelvin_rnd) * 33'(lcpe_pkg::DIV10_MULT);

    always_comb
    begin
        v_c = (in_intensity > 16'(lcpe_pkg::INTENSITY_MAX)) ? lcpe_pkg::INTENSITY_MAX
                                                            : in_intensity[9:0];
        h_c = (in_hue > 16'(lcpe_pkg::HUE_MAX)) ? lcpe_pkg::HUE_MAX : in_hue[8:0];
        s_c = (in_sat > 8'(lcpe_pkg::SAT_MAX)) ? lcpe_pkg::SAT_MAX : in_sat[6:0];
        priority if ($signed(in_tint) < -16'sd10)
            g_c = 5'd0;
        else if ($signed(in_tint) > 16'sd10)
            g_c = lcpe_pkg::TINT_TOP;
        else
            g_c = in_tint[4:0] + lcpe_pkg::TINT_SPAN;
    end

    always_comb
    begin
        kind_ok = (a_kind_reg == lcpe_pkg::KIND_STATUS) || (a_kind_reg == lcpe_pkg::KIND_POWER)
               || (a_kind_reg == lcpe_pkg::KIND_BRIGHT) || (a_kind_reg == lcpe_pkg::KIND_CCT)
               || (a_kind_reg == lcpe_pkg::KIND_HSI);
        advance  = a_valid_reg && (!q_status.full || !kind_ok);
        push     = a_valid_reg && kind_ok && !q_status.full;
        s_tready = !a_valid_reg || advance;
        accept   = s_tvalid && s_tready;
        a_valid_next = accept ? 1'b1 : (advance ? 1'b0 : a_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= a_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_kind_reg  <= s_tuser;
            a_power_reg <= s_tdata[0];
            a_v_reg     <= v_c;
            a_h_reg     <= h_c;
            a_s_reg     <= s_c;
            a_g_reg     <= g_c;
            a_t_reg     <= div_prod[lcpe_pkg::DIV10_SHIFT +: lcpe_pkg::TEMP_RAW_W];
        end
    end

    always_comb
    begin
        priority if (a_t_reg < lcpe_pkg::TEMP_RAW_W'(lcpe_pkg::TEMP_MIN))
            t_clamp = lcpe_pkg::TEMP_MIN;
        else if (a_t_reg > lcpe_pkg::TEMP_RAW_W'(lcpe_pkg::TEMP_MAX))
            t_clamp = lcpe_pkg::TEMP_MAX;
        else
            t_clamp = a_t_reg[10:0];
        t_sum   = t_clamp + lcpe_pkg::TEMP_OFFSET;
        wrap    = t_clamp > lcpe_pkg::TEMP_WRAP;
        t_field = wrap ? t_sum[9:0] : t_clamp[9:0];
    end

    always_comb
    begin
        pkt = '0;
        unique case (a_kind_reg)
            lcpe_pkg::KIND_STATUS:
                pkt[9] = lcpe_pkg::OP_STATUS;
            lcpe_pkg::KIND_POWER:
            begin
                pkt[8] = {7'd0, a_power_reg};
                pkt[9] = lcpe_pkg::OP_POWER;
            end
            lcpe_pkg::KIND_BRIGHT:
            begin
                pkt[7] = {a_v_reg[1:0], 6'd0};
                pkt[8] = a_v_reg[9:2];
                pkt[9] = lcpe_pkg::OP_BRIGHT;
            end
            lcpe_pkg::KIND_CCT:
            begin
                pkt[5] = {a_g_reg[2:0], 2'b00, wrap, 2'b00};
                pkt[6] = {t_field[3:0], 2'b00, a_g_reg[4:3]};
                pkt[7] = {a_v_reg[1:0], t_field[9:4]};
                pkt[8] = a_v_reg[9:2];
                pkt[9] = lcpe_pkg::OP_CCT;
            end
            lcpe_pkg::KIND_HSI:
            begin
                pkt[5] = {a_s_reg[1:0], 6'd0};
                pkt[6] = {a_h_reg[2:0], a_s_reg[6:2]};
                pkt[7] = {a_v_reg[1:0], a_h_reg[8:3]};
                pkt[8] = a_v_reg[9:2];
                pkt[9] = lcpe_pkg::OP_HSI;
            end
            default:
                pkt = '0;
        endcase
    end

    always_comb
    begin
        csum = '0;
        for (int i = 1; i < lcpe_pkg::PKT_LEN; i++)
            csum = csum + pkt[i];
    end

    always_comb
    begin
        push_data    = pkt;
        push_data[0] = csum;
    end

endmodule

// ----- rtl/lcpe_queue.sv -----
module lcpe_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  lcpe_pkg::packet_t       push_data,
    input  logic                    pop,
    output lcpe_pkg::packet_t       head,
    output lcpe_pkg::queue_status_t q_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcpe_pkg::packet_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assign head           = mem_reg[rd_ptr_reg];
    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == CNT_W'(DEPTH));

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CNT_W'(DEPTH)))
        else $error("request pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("request popped from an empty queue");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers differ while empty");

endmodule

// ----- rtl/lcpe_back.sv -----
module lcpe_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lcpe_pkg::packet_t       head,
    input  lcpe_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata,
    output logic                    m_tlast
);

    logic [lcpe_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                       out_valid_reg, out_valid_next;
    lcpe_pkg::byte_t            out_byte_reg;
    logic                       out_last_reg;
    logic                       load, at_end;

    always_comb
    begin
        load   = (!out_valid_reg || m_tready) && !q_status.empty;
        at_end = (idx_reg == lcpe_pkg::IDX_W'(lcpe_pkg::PKT_LEN - 1));
        pop    = load && at_end;
        idx_next = idx_reg;
        if (load)
            idx_next = at_end ? '0 : idx_reg + lcpe_pkg::IDX_W'(1);
        out_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= head[idx_reg];
            out_last_reg <= at_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg < lcpe_pkg::IDX_W'(lcpe_pkg::PKT_LEN))
        else $error("byte index out of range");

    a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (load && at_end) |=> (m_tvalid && m_tlast))
        else $error("final byte not marked last");

    a_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.empty |-> !pop)
        else $error("pop with no request queued");

endmodule

// ----- rtl/light_command_packet_encoder.sv -----
// Channel   Dir  Signals                     Contents
// s_*       in   tvalid tready tdata tuser   one lighting command request
// m_*       out  tvalid tready tdata tlast   packet bytes, checksum first
//
// Ten output bytes per request, sent by the byte-wide output serializer.
// An accepted request passes the front registers and the queue before its first byte is registered at the output.
// Unused kinds are dropped at the front and produce no bytes.
// Reset clears valid flags, queue pointers and count, and the byte index only.
// A stalled output holds its byte; the front keeps accepting until the queue fills.
module light_command_packet_encoder
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // power_on[0], intensity[16:1], kelvin[32:17], tint_offset[48:33],
    // hue[64:49], saturation[72:65], zero fill [79:73]
    input  logic [79:0] s_tdata,
    // kind[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // packet_byte[7:0]
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    lcpe_pkg::queue_status_t q_status;
    lcpe_pkg::packet_t       push_data;
    lcpe_pkg::packet_t       head;
    logic                    push;
    logic                    pop;

    lcpe_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    lcpe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status)
    );

    lcpe_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- bench/tb_light_command_packet_encoder.sv -----
`timescale 1ns / 100ps

module tb_light_command_packet_encoder;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 62;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 40;
    localparam int LIMIT_CYCLES = 200000;

    localparam logic [2:0] KIND_UNUSED_LO  = 3'd5;
    localparam logic [2:0] KIND_UNUSED_MID = 3'd6;
    localparam logic [2:0] KIND_UNUSED_HI  = 3'd7;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } packet_byte_t;

    class packet_scoreboard;
        packet_byte_t expected_q[$];
        int           mismatches;
        int           commands;
        int           bytes_seen;
        int           ignored;
        int           kind_count[5];

        function bit encode(input logic [2:0] kind, input logic [79:0] f,
                            output lcpe_pkg::packet_t pkt);
            logic [9:0]  v;
            logic [8:0]  h;
            logic [6:0]  s;
            logic [63:0] w;
            int          t;
            int          tw;
            int          g;
            int          sum;
            pkt = '0;
            v = (f[16:1] > lcpe_pkg::INTENSITY_MAX) ? lcpe_pkg::INTENSITY_MAX
                                                    : f[10:1];
            case (kind)
                lcpe_pkg::KIND_STATUS:
                begin
                    pkt[9] = lcpe_pkg::OP_STATUS;
                end
                lcpe_pkg::KIND_POWER:
                begin
                    pkt[8] = {7'b0, f[0]};
                    pkt[9] = lcpe_pkg::OP_POWER;
                end
                lcpe_pkg::KIND_BRIGHT:
                begin
                    pkt[7] = {v[1:0], 6'b0};
                    pkt[8] = v[9:2];
                    pkt[9] = lcpe_pkg::OP_BRIGHT;
                end
                lcpe_pkg::KIND_CCT:
                begin
                    t = (int'(f[32:17]) + int'(lcpe_pkg::KELVIN_ROUND)) / 10;
                    if (t < int'(lcpe_pkg::TEMP_MIN))
                        t = int'(lcpe_pkg::TEMP_MIN);
                    if (t > int'(lcpe_pkg::TEMP_MAX))
                        t = int'(lcpe_pkg::TEMP_MAX);
                    g = int'($signed(f[48:33])) + int'(lcpe_pkg::TINT_SPAN);
                    if (g < 0)
                        g = 0;
                    if (g > int'(lcpe_pkg::TINT_TOP))
                        g = int'(lcpe_pkg::TINT_TOP);
                    w = '0;
                    w[63:62] = v[1:0];
                    if (t <= int'(lcpe_pkg::TEMP_WRAP))
                    begin
                        w[61:52] = t[9:0];
                    end
                    else
                    begin
                        tw = t + int'(lcpe_pkg::TEMP_OFFSET);
                        w[61:52] = tw[9:0];
                        w[42] = 1'b1;
                    end
                    w[51:45] = g[6:0];
                    for (int k = 0; k < 8; k++)
                        pkt[k] = w[8*k +: 8];
                    pkt[8] = v[9:2];
                    pkt[9] = lcpe_pkg::OP_CCT;
                end
                lcpe_pkg::KIND_HSI:
                begin
                    h = (f[64:49] > lcpe_pkg::HUE_MAX) ? lcpe_pkg::HUE_MAX : f[57:49];
                    s = (f[72:65] > lcpe_pkg::SAT_MAX) ? lcpe_pkg::SAT_MAX : f[71:65];
                    pkt[5] = {s[1:0], 6'b0};
                    pkt[6] = {h[2:0], s[6:2]};
                    pkt[7] = {v[1:0], h[8:3]};
                    pkt[8] = v[9:2];
                    pkt[9] = lcpe_pkg::OP_HSI;
                end
                default:
                begin
                    return 1'b0;
                end
            endcase
            sum = 0;
            for (int k = 1; k < lcpe_pkg::PKT_LEN; k++)
                sum += pkt[k];
            pkt[0] = sum[7:0];
            return 1'b1;
        endfunction

        function void note_command(input logic [2:0] kind, input logic [79:0] f);
            lcpe_pkg::packet_t pkt;
            if (!encode(kind, f, pkt))
            begin
                ignored++;
                return;
            end
            commands++;
            kind_count[kind]++;
            for (int k = 0; k < lcpe_pkg::PKT_LEN; k++)
                expected_q.push_back('{value: pkt[k], last: (k == lcpe_pkg::PKT_LEN - 1)});
        endfunction

        function void check_byte(input logic [7:0] value, input logic last);
            packet_byte_t exp_b;
            bytes_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected packet byte %02h last %b", $realtime, value, last);
                return;
            end
            exp_b = expected_q.pop_front();
            if (value !== exp_b.value || last !== exp_b.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: packet byte mismatch: expected %02h last %b, got %02h last %b",
                             $realtime, exp_b.value, exp_b.last, value, last);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    packet_scoreboard sb = new();

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_req     = 0;
    int hold_left    = 0;
    int sent_valid;

    light_command_packet_encoder dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_command(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_byte(m_tdata, m_tlast);
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial
    begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("tb_light_command_packet_encoder: FAIL");
        $finish;
    end

    function automatic logic [79:0] pack_fields(input logic power_on,
                                                input logic [15:0] intensity,
                                                input logic [15:0] kelvin,
                                                input logic [15:0] tint_offset,
                                                input logic [15:0] hue,
                                                input logic [7:0] saturation);
        return {7'b0, saturation, hue, tint_offset, kelvin, intensity, power_on};
    endfunction

    function automatic logic [15:0] pick16(input int span);
        int mode;
        int val;
        mode = $urandom_range(3);
        case (mode)
            0:       val = $urandom_range(65535);
            1:       val = $urandom_range(span);
            2:       val = span + $urandom_range(6) - 3;
            default: val = $urandom_range(span + span / 10);
        endcase
        if (val < 0)
            val = 0;
        return val[15:0];
    endfunction

    function automatic logic [15:0] pick_tint();
        int val;
        if ($urandom_range(2) == 0)
            val = $urandom_range(65535);
        else
            val = $urandom_range(30) - 15;
        return val[15:0];
    endfunction

    task automatic send_cmd(input logic [2:0] kind, input logic [79:0] fields);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= fields;
        do
            @(posedge clk);
        while (!s_tready);
        if (kind <= lcpe_pkg::KIND_HSI)
            sent_valid++;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    task automatic send_random();
        logic [2:0] kind;
        if ($urandom_range(9) == 0)
            kind = 3'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
        else
            kind = 3'($urandom_range(lcpe_pkg::KIND_HSI, lcpe_pkg::KIND_STATUS));
        send_cmd(kind, pack_fields(1'($urandom_range(1)), pick16(1100), pick16(21000),
                                   pick_tint(), pick16(400), 8'($urandom_range(255))));
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        sent_valid   = 0;
        while (sent_valid < RANDOM_ITEMS)
            send_random();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_cmd(lcpe_pkg::KIND_STATUS,
                 pack_fields(1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff));
        send_cmd(lcpe_pkg::KIND_POWER,
                 pack_fields(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0));
        send_cmd(lcpe_pkg::KIND_POWER,
                 pack_fields(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0));
        send_cmd(lcpe_pkg::KIND_BRIGHT,
                 pack_fields(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0));
        send_cmd(lcpe_pkg::KIND_BRIGHT,
                 pack_fields(1'b0, 16'd1000, 16'd0, 16'd0, 16'd0, 8'd0));
        send_cmd(lcpe_pkg::KIND_BRIGHT,
                 pack_fields(1'b0, 16'd1001, 16'd0, 16'd0, 16'd0, 8'd0));
        send_cmd(lcpe_pkg::KIND_BRIGHT,
                 pack_fields(1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff));
        send_cmd(lcpe_pkg::KIND_CCT,
                 pack_fields(1'b0, 16'd3, 16'd0, 16'h8000, 16'd0, 8'd0));
        send_cmd(lcpe_pkg::KIND_CCT,
                 pack_fields(1'b0, 16'd1000, 16'd804, 16'h7fff, 16'd0, 8'd0));
        send_cmd(lcpe_pkg::KIND_CCT,
                 pack_fields(1'b0, 16'd500, 16'd10004, -16'sd10, 16'd0, 8'd0));
        send_cmd(lcpe_pkg::KIND_CCT,
                 pack_fields(1'b0, 16'd501, 16'd10005, 16'sd10, 16'd0, 8'd0));
        send_cmd(lcpe_pkg::KIND_CCT,
                 pack_fields(1'b0, 16'd2, 16'hffff, -16'sd11, 16'd0, 8'd0));
        send_cmd(lcpe_pkg::KIND_CCT,
                 pack_fields(1'b1, 16'hffff, 16'd20004, 16'sd11, 16'hffff, 8'hff));
        send_cmd(lcpe_pkg::KIND_CCT,
                 pack_fields(1'b0, 16'd1, 16'd19995, 16'sd0, 16'd0, 8'd0));
        send_cmd(lcpe_pkg::KIND_HSI,
                 pack_fields(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0));
        send_cmd(lcpe_pkg::KIND_HSI,
                 pack_fields(1'b0, 16'd1000, 16'd0, 16'd0, 16'd360, 8'd100));
        send_cmd(lcpe_pkg::KIND_HSI,
                 pack_fields(1'b0, 16'd999, 16'd0, 16'd0, 16'd361, 8'd101));
        send_cmd(lcpe_pkg::KIND_HSI,
                 pack_fields(1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff));
        send_cmd(lcpe_pkg::KIND_HSI,
                 pack_fields(1'b0, 16'd7, 16'd0, 16'd0, 16'd359, 8'd99));
        send_cmd(KIND_UNUSED_LO,
                 pack_fields(1'b1, 16'd5, 16'd5, 16'd5, 16'd5, 8'd5));
        send_cmd(KIND_UNUSED_MID,
                 pack_fields(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0));
        send_cmd(KIND_UNUSED_HI,
                 pack_fields(1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff));

        // hold the output off while requests keep coming
        hold_req = HOLD_CYCLES;
        for (int n = 0; n < 12; n++)
            send_random();

        run_phase(0, 0);
        run_phase(74, 0);
        run_phase(0, 74);
        run_phase(17, 17);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d commands: %0d status, %0d on/off, %0d brightness, %0d cct, %0d hsi",
                 sb.commands, sb.kind_count[lcpe_pkg::KIND_STATUS],
                 sb.kind_count[lcpe_pkg::KIND_POWER], sb.kind_count[lcpe_pkg::KIND_BRIGHT],
                 sb.kind_count[lcpe_pkg::KIND_CCT], sb.kind_count[lcpe_pkg::KIND_HSI]);
        $display("%0d packet bytes checked, %0d unused-kind requests dropped, %0d mismatches",
                 sb.bytes_seen, sb.ignored, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_light_command_packet_encoder: PASS");
        else
            $display("tb_light_command_packet_encoder: FAIL");
        $finish;
    end

endmodule

// ----- light_command_packet_encoder.f -----
rtl/lcpe_pkg.sv
rtl/lcpe_front.sv
rtl/lcpe_queue.sv
rtl/lcpe_back.sv
rtl/light_command_packet_encoder.sv
bench/tb_light_command_packet_encoder.sv
